// ----- rtl/qau_pkg.sv -----
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, command codes and product schedules of the quaternion unit.
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam logic [2:0] CMD_MUL  = 3'd0;
    localparam logic [2:0] CMD_CONJ = 3'd1;
    localparam logic [2:0] CMD_NORM = 3'd2;
    localparam logic [2:0] CMD_INV  = 3'd3;
    localparam logic [2:0] CMD_ROT  = 3'd4;
    localparam logic [2:0] CMD_MAT  = 3'd5;

    localparam int ACC_W   = 68;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [2:0] {
        OP_MUL,
        OP_CONJ,
        OP_NORM,
        OP_INV,
        OP_ROT,
        OP_MAT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [3:0][31:0] a;
        logic [3:0][31:0] b;
    } t_item;

    typedef struct packed {
        logic [1:0] u;
        logic [1:0] v;
        logic       neg;
        logic       dbl;
        logic       raw;
        logic [1:0] comp;
    } t_term;

    function automatic t_term mk_term(input logic [1:0] u, input logic [1:0] v,
                                      input logic neg, input logic dbl,
                                      input logic [1:0] comp);
        t_term t;
        t.u    = u;
        t.v    = v;
        t.neg  = neg;
        t.dbl  = dbl;
        t.raw  = 1'b0;
        t.comp = comp;
        return t;
    endfunction

    // Hamilton product q*r, four terms per component, x y z w = 0 1 2 3
    function automatic t_term qmul_term(input logic [3:0] k);
        t_term t;
        unique case (k)
            4'd0:  t = mk_term(2'd3, 2'd0, 1'b0, 1'b0, 2'd0);
            4'd1:  t = mk_term(2'd2, 2'd1, 1'b1, 1'b0, 2'd0);
            4'd2:  t = mk_term(2'd1, 2'd2, 1'b0, 1'b0, 2'd0);
            4'd3:  t = mk_term(2'd0, 2'd3, 1'b0, 1'b0, 2'd0);
            4'd4:  t = mk_term(2'd2, 2'd0, 1'b0, 1'b0, 2'd1);
            4'd5:  t = mk_term(2'd3, 2'd1, 1'b0, 1'b0, 2'd1);
            4'd6:  t = mk_term(2'd0, 2'd2, 1'b1, 1'b0, 2'd1);
            4'd7:  t = mk_term(2'd1, 2'd3, 1'b0, 1'b0, 2'd1);
            4'd8:  t = mk_term(2'd1, 2'd0, 1'b1, 1'b0, 2'd2);
            4'd9:  t = mk_term(2'd0, 2'd1, 1'b0, 1'b0, 2'd2);
            4'd10: t = mk_term(2'd3, 2'd2, 1'b0, 1'b0, 2'd2);
            4'd11: t = mk_term(2'd2, 2'd3, 1'b0, 1'b0, 2'd2);
            4'd12: t = mk_term(2'd0, 2'd0, 1'b1, 1'b0, 2'd3);
            4'd13: t = mk_term(2'd1, 2'd1, 1'b1, 1'b0, 2'd3);
            4'd14: t = mk_term(2'd2, 2'd2, 1'b1, 1'b0, 2'd3);
            default: t = mk_term(2'd3, 2'd3, 1'b0, 1'b0, 2'd3);
        endcase
        return t;
    endfunction

    // Rotation matrix row terms, eight per row
    function automatic t_term mat_term(input logic [1:0] row, input logic [2:0] k);
        t_term t;
        unique case ({row, k})
            5'b00_000: t = mk_term(2'd3, 2'd3, 1'b0, 1'b0, 2'd0);
            5'b00_001: t = mk_term(2'd0, 2'd0, 1'b0, 1'b0, 2'd0);
            5'b00_010: t = mk_term(2'd1, 2'd1, 1'b1, 1'b0, 2'd0);
            5'b00_011: t = mk_term(2'd2, 2'd2, 1'b1, 1'b0, 2'd0);
            5'b00_100: t = mk_term(2'd0, 2'd1, 1'b0, 1'b1, 2'd1);
            5'b00_101: t = mk_term(2'd3, 2'd2, 1'b0, 1'b1, 2'd1);
            5'b00_110: t = mk_term(2'd0, 2'd2, 1'b0, 1'b1, 2'd2);
            5'b00_111: t = mk_term(2'd3, 2'd1, 1'b1, 1'b1, 2'd2);
            5'b01_000: t = mk_term(2'd0, 2'd1, 1'b0, 1'b1, 2'd0);
            5'b01_001: t = mk_term(2'd3, 2'd2, 1'b1, 1'b1, 2'd0);
            5'b01_010: t = mk_term(2'd3, 2'd3, 1'b0, 1'b0, 2'd1);
            5'b01_011: t = mk_term(2'd0, 2'd0, 1'b1, 1'b0, 2'd1);
            5'b01_100: t = mk_term(2'd1, 2'd1, 1'b0, 1'b0, 2'd1);
            5'b01_101: t = mk_term(2'd2, 2'd2, 1'b1, 1'b0, 2'd1);
            5'b01_110: t = mk_term(2'd1, 2'd2, 1'b0, 1'b1, 2'd2);
            5'b01_111: t = mk_term(2'd3, 2'd0, 1'b0, 1'b1, 2'd2);
            5'b10_000: t = mk_term(2'd0, 2'd2, 1'b0, 1'b1, 2'd0);
            5'b10_001: t = mk_term(2'd3, 2'd1, 1'b0, 1'b1, 2'd0);
            5'b10_010: t = mk_term(2'd1, 2'd2, 1'b0, 1'b1, 2'd1);
            5'b10_011: t = mk_term(2'd3, 2'd0, 1'b1, 1'b1, 2'd1);
            5'b10_100: t = mk_term(2'd3, 2'd3, 1'b0, 1'b0, 2'd2);
            5'b10_101: t = mk_term(2'd0, 2'd0, 1'b1, 1'b0, 2'd2);
            5'b10_110: t = mk_term(2'd1, 2'd1, 1'b1, 1'b0, 2'd2);
            5'b10_111: t = mk_term(2'd2, 2'd2, 1'b0, 1'b0, 2'd2);
            default:   t = mk_term(2'd0, 2'd0, 1'b0, 1'b0, 2'd0);
        endcase
        return t;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [31:0] r;
        if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
            r = v[31:0];
        end else if (v[ACC_W-1]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// ----- rtl/qau_front.sv -----
// ----------------------------------------------------------------------------
// qau_front
// Input stage: accept words, decode the command, drop unused codes.
// ----------------------------------------------------------------------------
module qau_front import qau_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [2:0]   i_cmd,
    input  logic [255:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output t_item        o_item
);

    logic  r_valid;
    t_item r_item;
    t_item w_item;
    logic  w_keep;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        w_item.a = i_data[127:0];
        w_item.b = i_data[255:128];
        w_keep   = 1'b1;
        w_item.op = OP_MUL;
        unique case (i_cmd)
            CMD_MUL:  w_item.op = OP_MUL;
            CMD_CONJ: w_item.op = OP_CONJ;
            CMD_NORM: w_item.op = OP_NORM;
            CMD_INV:  w_item.op = OP_INV;
            CMD_ROT: begin
                w_item.op   = OP_ROT;
                w_item.b[3] = 32'd0;
            end
            CMD_MAT:  w_item.op = OP_MAT;
            default:  w_keep = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && w_keep;
            r_item  <= w_item;
        end
    end

endmodule

// ----- rtl/qau_queue.sv -----
// ----------------------------------------------------------------------------
// qau_queue
// Short FIFO of decoded items between the front and back parts.
// ----------------------------------------------------------------------------
module qau_queue import qau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    t_item          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_ready = r_count != (Q_AW+1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/qau_back.sv -----
// ----------------------------------------------------------------------------
// qau_back
// Execution: shared multiplier with accumulators, digit square root,
// bit-serial divider and the output register.
// ----------------------------------------------------------------------------
module qau_back import qau_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    output logic         o_pop,
    input  t_item        i_item,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [127:0] o_data,
    output logic         o_last,
    output logic         o_zn
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int DW = 65 - FRAC_BITS;
    localparam int CW = $clog2(NW);

    typedef enum logic [2:0] {S_IDLE, S_MAC, S_SQRT, S_DIV, S_EMIT} t_state;

    t_state                  r_state;
    t_op                     r_op;
    logic [3:0][31:0]        r_a;
    logic [3:0][31:0]        r_b;
    logic [3:0][31:0]        r_t;
    logic signed [ACC_W-1:0] r_acc [4];
    logic [3:0]              r_step;
    logic                    r_issue_done;
    logic                    r_phase;
    logic [1:0]              r_row;
    logic signed [65:0]      r_prod;
    t_term                   r_tag;
    logic                    r_tag_v;
    logic [63:0]             r_sq_val;
    logic [35:0]             r_sq_rem;
    logic [31:0]             r_root;
    logic [CW-1:0]           r_cnt;
    logic [DW-1:0]           r_div;
    logic [DW-1:0]           r_rem;
    logic [NW-1:0]           r_num;
    logic [NW-1:0]           r_quo;
    logic                    r_neg;
    logic [1:0]              r_k;
    logic [3:0][31:0]        r_res;
    logic                    r_last;
    logic                    r_zn;
    logic                    r_o_valid;
    logic [127:0]            r_o_data;
    logic                    r_o_last;
    logic                    r_o_zn;

    t_term                   w_term;
    logic [3:0]              w_nlast;
    logic signed [32:0]      w_u;
    logic signed [32:0]      w_v;
    logic signed [65:0]      w_prod;
    logic signed [65:0]      w_sh;
    logic signed [ACC_W-1:0] w_ext;
    logic signed [ACC_W-1:0] w_add;
    logic [ACC_W-1:0]        w_s;
    logic                    w_wrap;
    logic [DW-1:0]           w_n2;
    logic [35:0]             w_sq_sh;
    logic [35:0]             w_sq_trial;
    logic                    w_sq_ge;
    logic [35:0]             w_sq_rem_n;
    logic [31:0]             w_root_n;
    logic [DW:0]             w_dv_sh;
    logic                    w_dv_ge;
    logic [DW-1:0]           w_rem_n;
    logic [NW-1:0]           w_quo_n;
    logic [31:0]             w_dres;
    logic [1:0]              w_dv_idx;
    logic signed [32:0]      w_dv_val;
    logic [32:0]             w_dv_mag;
    logic [NW-1:0]           w_dv_num;
    logic [3:0][31:0]        w_conj;

    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
    assign o_last  = r_o_last;
    assign o_zn    = r_o_zn;

    always_comb begin
        unique case (r_op)
            OP_MAT: begin
                w_term  = mat_term(r_row, r_step[2:0]);
                w_nlast = 4'd7;
            end
            OP_NORM, OP_INV: begin
                w_term     = mk_term(r_step[1:0], r_step[1:0], 1'b0, 1'b0, 2'd0);
                w_term.raw = 1'b1;
                w_nlast    = 4'd3;
            end
            default: begin
                w_term  = qmul_term(r_step);
                w_nlast = 4'd15;
            end
        endcase

        if (r_op == OP_ROT && r_phase) begin
            w_u = $signed({r_t[w_term.u][31], r_t[w_term.u]});
            if (w_term.v == 2'd3) begin
                w_v = $signed({r_a[3][31], r_a[3]});
            end else begin
                w_v = -$signed({r_a[w_term.v][31], r_a[w_term.v]});
            end
        end else begin
            w_u = $signed({r_a[w_term.u][31], r_a[w_term.u]});
            if (r_op == OP_MUL || r_op == OP_ROT) begin
                w_v = $signed({r_b[w_term.v][31], r_b[w_term.v]});
            end else begin
                w_v = $signed({r_a[w_term.v][31], r_a[w_term.v]});
            end
        end
        w_prod = w_u * w_v;

        w_sh  = r_tag.raw ? r_prod : (r_prod >>> FRAC_BITS);
        w_ext = $signed({{(ACC_W-66){w_sh[65]}}, w_sh});
        if (r_tag.dbl) begin
            w_ext = w_ext <<< 1;
        end
        w_add = r_tag.neg ? -w_ext : w_ext;

        w_s    = r_acc[0];
        w_wrap = |w_s[ACC_W-1:64];
        w_n2   = w_wrap ? {1'b1, {(64-FRAC_BITS){1'b0}}} : {1'b0, w_s[63:FRAC_BITS]};

        w_sq_sh    = {r_sq_rem[33:0], r_sq_val[63:62]};
        w_sq_trial = {2'b00, r_root, 2'b01};
        w_sq_ge    = w_sq_sh >= w_sq_trial;
        w_sq_rem_n = w_sq_ge ? (w_sq_sh - w_sq_trial) : w_sq_sh;
        w_root_n   = {r_root[30:0], w_sq_ge};

        w_dv_sh = {r_rem, r_num[NW-1]};
        w_dv_ge = w_dv_sh >= {1'b0, r_div};
        w_rem_n = w_dv_ge ? DW'(w_dv_sh - {1'b0, r_div}) : w_dv_sh[DW-1:0];
        w_quo_n = {r_quo[NW-2:0], w_dv_ge};
        if (!r_neg) begin
            w_dres = (|w_quo_n[NW-1:31]) ? 32'h7FFF_FFFF : w_quo_n[31:0];
        end else if ((|w_quo_n[NW-1:32]) || (w_quo_n[31] && (|w_quo_n[30:0]))) begin
            w_dres = 32'h8000_0000;
        end else begin
            w_dres = -w_quo_n[31:0];
        end

        w_dv_idx = (r_state == S_DIV) ? r_k + 2'd1 : 2'd0;
        if (r_op == OP_NORM || w_dv_idx == 2'd3) begin
            w_dv_val = $signed({r_a[w_dv_idx][31], r_a[w_dv_idx]});
        end else begin
            w_dv_val = -$signed({r_a[w_dv_idx][31], r_a[w_dv_idx]});
        end
        w_dv_mag = w_dv_val[32] ? 33'(-w_dv_val) : 33'(w_dv_val);
        w_dv_num = {w_dv_mag[31:0], {FRAC_BITS{1'b0}}};

        for (int i = 0; i < 3; i++) begin
            w_conj[i] = (i_item.a[i] == 32'h8000_0000) ? 32'h7FFF_FFFF : -i_item.a[i];
        end
        w_conj[3] = i_item.a[3];
    end

    always_ff @(posedge i_clk) begin
        r_tag_v <= 1'b0;
        if (r_tag_v) begin
            r_acc[r_tag.comp] <= r_acc[r_tag.comp] + w_add;
        end
        if (r_o_valid && i_ready) begin
            r_o_valid <= 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    r_op         <= i_item.op;
                    r_a          <= i_item.a;
                    r_b          <= i_item.b;
                    r_step       <= '0;
                    r_issue_done <= 1'b0;
                    r_phase      <= 1'b0;
                    r_row        <= '0;
                    for (int i = 0; i < 4; i++) begin
                        r_acc[i] <= '0;
                    end
                    if (i_item.op == OP_CONJ) begin
                        r_res   <= w_conj;
                        r_last  <= 1'b1;
                        r_zn    <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_MAC;
                    end
                end
            end
            S_MAC: begin
                if (!r_issue_done) begin
                    r_prod  <= w_prod;
                    r_tag   <= w_term;
                    r_tag_v <= 1'b1;
                    r_step  <= r_step + 1'b1;
                    if (r_step == w_nlast) begin
                        r_issue_done <= 1'b1;
                    end
                end else if (!r_tag_v) begin
                    r_last <= 1'b1;
                    r_zn   <= 1'b0;
                    r_cnt  <= '0;
                    r_k    <= '0;
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_num  <= w_dv_num;
                    r_neg  <= w_dv_val[32];
                    unique case (r_op)
                        OP_MUL: begin
                            for (int i = 0; i < 4; i++) begin
                                r_res[i] <= sat32(r_acc[i]);
                            end
                            r_state <= S_EMIT;
                        end
                        OP_ROT: begin
                            if (!r_phase) begin
                                for (int i = 0; i < 4; i++) begin
                                    r_t[i]   <= sat32(r_acc[i]);
                                    r_acc[i] <= '0;
                                end
                                r_phase      <= 1'b1;
                                r_step       <= '0;
                                r_issue_done <= 1'b0;
                            end else begin
                                for (int i = 0; i < 3; i++) begin
                                    r_res[i] <= sat32(r_acc[i]);
                                end
                                r_res[3] <= '0;
                                r_state  <= S_EMIT;
                            end
                        end
                        OP_MAT: begin
                            for (int i = 0; i < 3; i++) begin
                                r_res[i] <= sat32(r_acc[i]);
                            end
                            r_res[3] <= '0;
                            r_last   <= r_row == 2'd2;
                            r_state  <= S_EMIT;
                        end
                        OP_NORM: begin
                            if (w_s == '0) begin
                                r_res   <= r_a;
                                r_zn    <= 1'b1;
                                r_state <= S_EMIT;
                            end else if (w_wrap) begin
                                r_div   <= DW'({1'b1, 32'd0});
                                r_state <= S_DIV;
                            end else begin
                                r_sq_val <= w_s[63:0];
                                r_sq_rem <= '0;
                                r_root   <= '0;
                                r_state  <= S_SQRT;
                            end
                        end
                        OP_INV: begin
                            if (w_n2 == '0) begin
                                r_res   <= '0;
                                r_zn    <= 1'b1;
                                r_state <= S_EMIT;
                            end else begin
                                r_div   <= w_n2;
                                r_state <= S_DIV;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
            end
            S_SQRT: begin
                r_sq_val <= {r_sq_val[61:0], 2'b00};
                r_sq_rem <= w_sq_rem_n;
                r_root   <= w_root_n;
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == CW'(31)) begin
                    r_div   <= DW'(w_root_n);
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
            end
            S_DIV: begin
                r_rem <= w_rem_n;
                r_quo <= w_quo_n;
                r_num <= {r_num[NW-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW-1)) begin
                    r_res[r_k] <= w_dres;
                    r_cnt      <= '0;
                    r_rem      <= '0;
                    r_quo      <= '0;
                    r_num      <= w_dv_num;
                    r_neg      <= w_dv_val[32];
                    r_k        <= w_dv_idx;
                    if (r_k == 2'd3) begin
                        r_state <= S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (!r_o_valid || i_ready) begin
                    r_o_valid <= 1'b1;
                    r_o_data  <= r_res;
                    r_o_last  <= r_last;
                    r_o_zn    <= r_zn;
                    if (r_op == OP_MAT && r_row != 2'd2) begin
                        r_row        <= r_row + 1'b1;
                        r_step       <= '0;
                        r_issue_done <= 1'b0;
                        for (int i = 0; i < 4; i++) begin
                            r_acc[i] <= '0;
                        end
                        r_state <= S_MAC;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
            end
            default: r_state <= S_IDLE;
        endcase

        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_tag_v   <= 1'b0;
        end
    end

endmodule

// ----- rtl/quaternion_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Signed fixed-point quaternion product, conjugate, normalize, inverse,
// vector rotation and rotation matrix over stream ports.
// ----------------------------------------------------------------------------
// The input stage takes one word per cycle, while the queue has room, into a four-entry
// queue, so the slave side keeps flowing while the execution part works. One shared 33x33
// multiplier issues a product per cycle; the square root gives one digit per cycle and the
// division one quotient bit per cycle. Results leave through a registered master port.
module quaternion_arithmetic_unit import qau_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
    input  logic [2:0]   s_axis_tuser,  // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // res_x, res_y, res_z, res_w
    output logic         m_axis_tlast,
    output logic [0:0]   m_axis_tuser   // zero_norm
);

    logic  w_f_valid;
    logic  w_f_ready;
    t_item w_f_item;
    logic  w_q_valid;
    logic  w_q_pop;
    t_item w_q_item;

    qau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (s_axis_tuser),
        .i_data  (s_axis_tdata),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_item  (w_f_item)
    );

    qau_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item)
    );

    qau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_pop     (w_q_pop),
        .i_item    (w_q_item),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_last    (m_axis_tlast),
        .o_zn      (m_axis_tuser[0])
    );

    a_zero_norm_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && m_axis_tlast)
        else $error("zero norm result not cleared");

    a_matrix_row_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[127:96] == '0 && !m_axis_tuser[0])
        else $error("matrix row carries w or flag");

endmodule

// ----- tb/quaternion_arithmetic_unit_test.sv -----
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_test
// Self-checking bench for the quaternion unit: a directed table of commands
// and edge values, then random words, all checked against a fixed-point
// model of the product, conjugate, normalize, inverse, rotate and matrix.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_test import qau_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam logic [2:0] CMD_SKIP6 = 3'd6;
    localparam logic [2:0] CMD_SKIP7 = 3'd7;
    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] a [4];
        logic [31:0] b [4];
    } quat_word_t;

    typedef struct {
        logic [31:0] r [4];
        logic        last;
        logic        zn;
    } quat_res_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata = '0;  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
    logic [2:0]   s_axis_tuser = '0;  // command
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;       // res_x, res_y, res_z, res_w
    logic         m_axis_tlast;
    logic [0:0]   m_axis_tuser;       // zero_norm

    quaternion_arithmetic_unit #(.FRAC_BITS(FRAC)) DUT (.*);

    always #4 i_clk = ~i_clk;

    quat_res_t expected_results[$];
    int        mismatch_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        recv_hold = 1'b0;

    function automatic longint clamp32(longint v);
        if (v > MAXV) return MAXV;
        if (v < MINV) return MINV;
        return v;
    endfunction

    function automatic longint fx_mul(longint u, longint v);
        return (u * v) >>> FRAC;
    endfunction

    function automatic void hamilton(longint q[4], longint r[4], output longint o[4]);
        o[0] = fx_mul(q[3], r[0]) - fx_mul(q[2], r[1]) + fx_mul(q[1], r[2])
             + fx_mul(q[0], r[3]);
        o[1] = fx_mul(q[2], r[0]) + fx_mul(q[3], r[1]) - fx_mul(q[0], r[2])
             + fx_mul(q[1], r[3]);
        o[2] = -fx_mul(q[1], r[0]) + fx_mul(q[0], r[1]) + fx_mul(q[3], r[2])
             + fx_mul(q[2], r[3]);
        o[3] = -fx_mul(q[0], r[0]) - fx_mul(q[1], r[1]) - fx_mul(q[2], r[2])
             + fx_mul(q[3], r[3]);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0, bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic quat_res_t mk_res(longint v[4], logic last, logic zn);
        quat_res_t e;
        for (int j = 0; j < 4; j++) e.r[j] = 32'(clamp32(v[j]));
        e.last = last;
        e.zn = zn;
        return e;
    endfunction

    function automatic void predict_quat(quat_word_t w);
        longint a[4], b[4], r[4], t[4], c[4];
        longint unsigned sq, s, norm, n2;
        bit wrapped;
        longint x, y, z, ww, xx, yy, zz, qw, xy, xz, yz, wx, wy, wz;
        for (int i = 0; i < 4; i++) begin
            a[i] = longint'($signed(w.a[i]));
            b[i] = longint'($signed(w.b[i]));
        end
        c[0] = -a[0]; c[1] = -a[1]; c[2] = -a[2]; c[3] = a[3];
        case (w.cmd)
            CMD_MUL: begin
                hamilton(a, b, r);
                expected_results.push_back(mk_res(r, 1'b1, 1'b0));
            end
            CMD_CONJ: expected_results.push_back(mk_res(c, 1'b1, 1'b0));
            CMD_NORM, CMD_INV: begin
                s = 0;
                wrapped = 1'b0;
                for (int i = 0; i < 4; i++) begin
                    sq = longint'(a[i] * a[i]);
                    s += sq;
                    if (s < sq) wrapped = 1'b1;
                end
                if (w.cmd == CMD_NORM) begin
                    if (!wrapped && s == 0) begin
                        expected_results.push_back(mk_res(a, 1'b1, 1'b1));
                    end else begin
                        norm = wrapped ? (64'd1 << 32) : int_sqrt(s);
                        for (int i = 0; i < 4; i++) r[i] = (a[i] <<< FRAC) / longint'(norm);
                        expected_results.push_back(mk_res(r, 1'b1, 1'b0));
                    end
                end else begin
                    n2 = wrapped ? (64'd1 << (64 - FRAC)) : (s >> FRAC);
                    if (n2 == 0) begin
                        r = '{0, 0, 0, 0};
                        expected_results.push_back(mk_res(r, 1'b1, 1'b1));
                    end else begin
                        for (int i = 0; i < 4; i++) r[i] = (c[i] <<< FRAC) / longint'(n2);
                        expected_results.push_back(mk_res(r, 1'b1, 1'b0));
                    end
                end
            end
            CMD_ROT: begin
                b[3] = 0;
                hamilton(a, b, t);
                for (int i = 0; i < 4; i++) t[i] = clamp32(t[i]);
                hamilton(t, c, r);
                r[3] = 0;
                expected_results.push_back(mk_res(r, 1'b1, 1'b0));
            end
            CMD_MAT: begin
                x = a[0]; y = a[1]; z = a[2]; qw = a[3];
                xx = fx_mul(x, x); yy = fx_mul(y, y); zz = fx_mul(z, z);
                ww = fx_mul(qw, qw);
                xy = fx_mul(x, y); xz = fx_mul(x, z); yz = fx_mul(y, z);
                wx = fx_mul(qw, x); wy = fx_mul(qw, y); wz = fx_mul(qw, z);
                r = '{ww + xx - yy - zz, 2 * (xy + wz), 2 * (xz - wy), 0};
                expected_results.push_back(mk_res(r, 1'b0, 1'b0));
                r = '{2 * (xy - wz), ww - xx + yy - zz, 2 * (yz + wx), 0};
                expected_results.push_back(mk_res(r, 1'b0, 1'b0));
                r = '{2 * (xz + wy), 2 * (yz - wx), ww - xx - yy + zz, 0};
                expected_results.push_back(mk_res(r, 1'b1, 1'b0));
            end
            default: ;
        endcase
    endfunction

    // directed table; typed results are checked in addition to the model
    typedef struct {
        quat_word_t w;
        bit         typed;
        quat_res_t  res;
    } dir_row_t;

    function automatic quat_word_t mk_word(logic [2:0] cmd, logic [31:0] ax, logic [31:0] ay,
                                           logic [31:0] az, logic [31:0] aw,
                                           logic [31:0] bx, logic [31:0] by,
                                           logic [31:0] bz, logic [31:0] bw);
        quat_word_t w;
        w.cmd = cmd;
        w.a = '{ax, ay, az, aw};
        w.b = '{bx, by, bz, bw};
        return w;
    endfunction

    function automatic quat_word_t rand_word();
        quat_word_t w;
        int kind;
        w.cmd = 3'($urandom_range(0, 99) < 3 ? $urandom_range(6, 7) : $urandom_range(0, 5));
        for (int i = 0; i < 4; i++) begin
            kind = $urandom_range(0, 9);
            w.a[i] = (kind < 6) ? 32'($signed(20'($urandom))) :
                     (kind < 8) ? $urandom : 32'($signed(18'($urandom)));
            kind = $urandom_range(0, 9);
            w.b[i] = (kind < 6) ? 32'($signed(22'($urandom))) : $urandom;
        end
        if ((w.cmd == CMD_NORM || w.cmd == CMD_INV) && $urandom_range(0, 9) == 0)
            w.a = '{0, 0, 0, 32'($urandom_range(0, 255)) * (w.cmd == CMD_NORM ? 0 : 1)};
        return w;
    endfunction

    quat_res_t typed_results[$];
    bit        typed_flags[$];

    // hold the word until accepted; leave valid high so the next word can follow
    task automatic send_word(quat_word_t w);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata <= {w.b[3], w.b[2], w.b[1], w.b[0], w.a[3], w.a[2], w.a[1], w.a[0]};
        s_axis_tuser <= w.cmd;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_quat(w);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (recv_hold) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        quat_res_t e;
        logic [31:0] act [4];
        bit bad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            for (int j = 0; j < 4; j++) act[j] = m_axis_tdata[32*j +: 32];
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word %h last %b zn %b", m_axis_tdata,
                             m_axis_tlast, m_axis_tuser);
            end else begin
                e = expected_results.pop_front();
                bad = (act != e.r) || (m_axis_tlast !== e.last) || (m_axis_tuser[0] !== e.zn);
                if (typed_flags.size() != 0) begin
                    if (typed_flags.pop_front() && ((typed_results[0].r != act)
                        || (typed_results[0].last !== m_axis_tlast)
                        || (typed_results[0].zn !== m_axis_tuser[0]))) bad = 1'b1;
                    void'(typed_results.pop_front());
                end
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %h %h %h %h l%b z%b act %h %h %h %h l%b z%b",
                                 e.r[0], e.r[1], e.r[2], e.r[3], e.last, e.zn,
                                 act[0], act[1], act[2], act[3], m_axis_tlast,
                                 m_axis_tuser);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        dir_row_t rows[$];
        quat_res_t zr, one_r;
        localparam logic [31:0] ONE = 32'h0001_0000;
        localparam logic [31:0] MX = 32'h7FFF_FFFF;
        localparam logic [31:0] MN = 32'h8000_0000;
        localparam logic [31:0] M1 = 32'hFFFF_FFFF;

        zr.r = '{0, 0, 0, 0}; zr.last = 1'b1; zr.zn = 1'b1;
        one_r.r = '{0, 0, 0, ONE}; one_r.last = 1'b1; one_r.zn = 1'b0;
        rows.push_back('{mk_word(CMD_MUL, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b1, one_r});
        rows.push_back('{mk_word(CMD_MUL, MX, MN, MX, MN, MX, MN, M1, MX), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_MUL, MN, MN, MN, MN, MN, MN, MN, MN), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_CONJ, MN, MX, M1, MN, 0, 0, 0, 0), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_CONJ, ONE, 2, 3, 4, M1, M1, M1, M1), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_NORM, 0, 0, 0, 0, 5, 6, 7, 8), 1'b1, zr});
        rows.push_back('{mk_word(CMD_NORM, 0, 0, 0, 32'h0002_0000, 0, 0, 0, 0), 1'b1, one_r});
        rows.push_back('{mk_word(CMD_NORM, MN, MN, MN, MN, 0, 0, 0, 0), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_NORM, MX, 1, M1, 0, 0, 0, 0, 0), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_INV, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zr});
        rows.push_back('{mk_word(CMD_INV, 1, 1, 1, 1, 0, 0, 0, 0), 1'b1, zr});
        rows.push_back('{mk_word(CMD_INV, 0, 0, 0, ONE, 0, 0, 0, 0), 1'b1, one_r});
        rows.push_back('{mk_word(CMD_INV, MN, MN, MN, MN, 0, 0, 0, 0), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_INV, 0, 0, 1, 32'h100, 0, 0, 0, 0), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_ROT, 0, 0, 0, ONE, ONE, 2, M1, MX), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_ROT, MX, MN, MX, MN, MN, MX, MN, 0), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_ROT, 32'hB505, 0, 0, 32'hB505, 0, ONE, 0, 0), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_MAT, 0, 0, 0, ONE, 0, 0, 0, 0), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_MAT, MX, MN, MX, MN, 0, 0, 0, 0), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_MAT, MN, MN, MN, MN, M1, M1, M1, M1), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_SKIP6, 1, 2, 3, 4, 5, 6, 7, 8), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_SKIP7, M1, M1, M1, M1, M1, M1, M1, M1), 1'b0, one_r});
        rows.push_back('{mk_word(CMD_MUL, M1, M1, M1, M1, M1, M1, M1, M1), 1'b0, one_r});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            send_word(rows[k].w);
            if (rows[k].w.cmd <= CMD_MAT) begin
                typed_flags.push_back(rows[k].typed);
                typed_results.push_back(rows[k].res);
                if (rows[k].w.cmd == CMD_MAT) begin
                    repeat (2) begin
                        typed_flags.push_back(1'b0);
                        typed_results.push_back(one_r);
                    end
                end
            end
        end
        drain();

        // hold the output for a long stretch while the queue fills
        recv_hold = 1'b1;
        fork
            begin
                repeat (600) @(negedge i_clk);
                recv_hold = 1'b0;
            end
            for (int k = 0; k < 8; k++) send_word(rand_word());
        join
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 74 : 0;
            recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 18 : 0;
            for (int k = 0; k < 84; k++) begin
                send_word(rand_word());
                if (k == 40) drain();
            end
        end
        drain();
        repeat (1500) @(negedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/qau_pkg.sv
rtl/qau_front.sv
rtl/qau_queue.sv
rtl/qau_back.sv
rtl/quaternion_arithmetic_unit.sv
tb/quaternion_arithmetic_unit_test.sv
